// ----- rtl/core/cmb_pkg.sv -----
// Shared constants, types and register codes for the five-point cross mean filter.
// No dependencies; every module of the filter imports this package.
package cmb_pkg;

   // Line geometry
   localparam int MAX_WIDTH    = 2048;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int MAX_HEIGHT   = 4096;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   // Width compares need room for MAX_WIDTH itself and for the raw register
   localparam int WCMP_W = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;
   localparam int HCMP_W = HEIGHT_REG_W;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Pixel packing
   localparam int PIX_W       = 32;
   localparam int CHAN_W      = 8;
   localparam int NUM_COLOUR  = 3;
   localparam int ALPHA_SHIFT = 24;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Truncating divide by five: floor(s * 13108 / 2^16) is exact for s <= 1275
   localparam int SUM_W       = 11;
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_FIVE = 14'd13108;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // Position and result plan of one accepted pixel
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             has_above;
      logic             interior;
      logic             last_row;
   } cmb_pos_type;

endpackage

// ----- rtl/core/cross_mean_blur_argb_unit.sv -----
// Five-point cross mean filter on a raster stream of ARGB pixels.
// An accepted pixel is registered in the compute stage, and its results in the output register.
// Throughput: one pixel per cycle outside the last row while the result channel is not
// stalled; a last-row pixel with a row above emits two results, moved one per cycle.
// Reset clears the position counters and sets the frame to 640 x 480; the line
// stores are not cleared and read as undefined until written.
module cross_mean_blur_argb_unit import cmb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIX_W-1:0]       rsp_pixel_out,
   output logic [COL_W-1:0]       rsp_column,
   output logic [ROW_W-1:0]       rsp_row,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmb_pos_type      pos;
   logic [COL_W-1:0] right_col;
   logic             accept;
   logic [PIX_W-1:0] above_px;
   logic [PIX_W-1:0] right_px;
   logic [PIX_W-1:0] up_px;
   logic [PIX_W-1:0] mean_px;

   // Compute stage, holding the item while the read data is valid
   logic             s2_valid_ff,    s2_valid_in;
   logic             above_pend_ff,  above_pend_in;
   logic             self_pend_ff,   self_pend_in;
   logic [PIX_W-1:0] s2_pixel_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic             s2_interior_ff;
   logic             s2_last_row_ff;
   logic [PIX_W-1:0] left_ff;

   // Output register
   logic             rsp_valid_ff,   rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic             rsp_last_ff;

   logic out_free;
   logic any_pend;
   logic emit;
   logic retire;

   cmb_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (accept),
      .pos       (pos),
      .right_col (right_col)
   );

   cmb_line_stores u_stores (
      .clock          (clock),
      .rd_en          (accept),
      .rd_col         (pos.col),
      .right_col      (right_col),
      .new_pixel      (req_pixel_in),
      .older_wr_en    (retire),
      .older_wr_col   (s2_col_ff),
      .older_wr_pixel (above_px),
      .above_px       (above_px),
      .right_px       (right_px),
      .up_px          (up_px)
   );

   cmb_mean u_mean (
      .up_px    (up_px),
      .down_px  (s2_pixel_ff),
      .left_px  (left_ff),
      .right_px (right_px),
      .self_px  (above_px),
      .mean_px  (mean_px)
   );

   // Handshake: one result per cycle if output is free; retire the item with its last result
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      any_pend  = above_pend_ff || self_pend_ff;
      emit      = s2_valid_ff && any_pend && out_free;
      retire    = s2_valid_ff &&
                  (!any_pend || (out_free && !(above_pend_ff && self_pend_ff)));
      req_ready = !s2_valid_ff || retire;
      accept    = req_valid && req_ready;
   end

   // Next state of the compute stage and the output register
   always_comb begin
      s2_valid_in   = s2_valid_ff;
      above_pend_in = above_pend_ff;
      self_pend_in  = self_pend_ff;
      if (accept) begin
         s2_valid_in   = 1'b1;
         above_pend_in = pos.has_above;
         self_pend_in  = pos.last_row;
      end else begin
         if (retire)
            s2_valid_in = 1'b0;
         if (emit && above_pend_ff)
            above_pend_in = 1'b0;
         else if (emit)
            self_pend_in = 1'b0;
      end

      if (emit)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         above_pend_ff <= 1'b0;
         self_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s2_valid_ff   <= s2_valid_in;
         above_pend_ff <= above_pend_in;
         self_pend_ff  <= self_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the accepted pixel and its plan
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_pixel_ff    <= req_pixel_in;
         s2_col_ff      <= pos.col;
         s2_row_ff      <= pos.row;
         s2_interior_ff <= pos.interior;
         s2_last_row_ff <= pos.last_row;
      end
   end

   // Hold the above pixel of the retiring item as the next item's left neighbour
   always_ff @(posedge clock) begin
      if (retire)
         left_ff <= above_px;
   end

   // Load the output register: the pixel above first, then the pixel itself
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_col_ff <= s2_col_ff;
         if (above_pend_ff) begin
            rsp_pixel_ff <= s2_interior_ff ? mean_px : above_px;
            rsp_row_ff   <= s2_row_ff - ROW_W'(1);
            rsp_last_ff  <= !s2_last_row_ff;
         end else begin
            rsp_pixel_ff <= s2_pixel_ff;
            rsp_row_ff   <= s2_row_ff;
            rsp_last_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_column      = rsp_col_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // An accepted pixel occupies the compute stage in the next cycle
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s2_valid_ff)
      else $error("accepted pixel did not enter the compute stage");

   // Pending results only exist for an item in the compute stage
   a_pend_needs_item: assert property (@(posedge clock) disable iff (reset)
      !s2_valid_ff |-> !(above_pend_ff || self_pend_ff))
      else $error("result pending with an empty compute stage");

   // An item never retires with two results still undelivered
   a_retire_one_left: assert property (@(posedge clock) disable iff (reset)
      retire |-> !(above_pend_ff && self_pend_ff))
      else $error("item retired with both results pending");

   // A result that is not the last of its run is always followed by the pixel itself
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (emit && above_pend_ff && s2_last_row_ff) |=> self_pend_ff)
      else $error("last-row pixel lost its own result");

endmodule

// ----- rtl/core/cmb_scan.sv -----
// Frame geometry registers and raster position tracking for the cross mean filter.
// Depends on cmb_pkg.
module cmb_scan import cmb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   step,
   output cmb_pos_type            pos,
   output logic [COL_W-1:0]       right_col
);

   logic [WIDTH_REG_W-1:0]  width_ff,  width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        col_ff,    col_in;
   logic [ROW_W-1:0]        row_ff,    row_in;

   logic [WCMP_W-1:0] w_eff;
   logic [HCMP_W-1:0] h_eff;
   logic [WCMP_W-1:0] cur_col;
   logic [HCMP_W-1:0] cur_row;
   logic [WCMP_W-1:0] nxt_col;
   logic [HCMP_W-1:0] nxt_row;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the geometry to the supported range
   always_comb begin
      if (width_ff == '0)
         w_eff = WCMP_W'(1);
      else if (WCMP_W'(width_ff) > WCMP_W'(MAX_WIDTH))
         w_eff = WCMP_W'(MAX_WIDTH);
      else
         w_eff = WCMP_W'(width_ff);
      if (height_ff == '0)
         h_eff = HCMP_W'(1);
      else if (height_ff > HCMP_W'(MAX_HEIGHT))
         h_eff = HCMP_W'(MAX_HEIGHT);
      else
         h_eff = height_ff;
   end

   // Resolve the position of the offered pixel and the position after it
   always_comb begin
      cur_col = WCMP_W'(col_ff);
      cur_row = HCMP_W'(row_ff);
      if (cur_col >= w_eff) begin
         cur_col = '0;
         cur_row = cur_row + HCMP_W'(1);
      end
      if (cur_row >= h_eff)
         cur_row = '0;

      nxt_col = cur_col + WCMP_W'(1);
      nxt_row = cur_row;
      if (nxt_col >= w_eff) begin
         nxt_col = '0;
         nxt_row = cur_row + HCMP_W'(1);
         if (nxt_row >= h_eff)
            nxt_row = '0;
      end

      pos.col       = cur_col[COL_W-1:0];
      pos.row       = cur_row[ROW_W-1:0];
      pos.has_above = (cur_row != '0);
      pos.last_row  = (cur_row == h_eff - HCMP_W'(1));
      pos.interior  = (cur_row >= HCMP_W'(2)) && (cur_col != '0) &&
                      (cur_col + WCMP_W'(1) < w_eff);
      right_col     = cur_col[COL_W-1:0] + COL_W'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         col_in = nxt_col[COL_W-1:0];
         row_in = nxt_row[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(RESET_WIDTH);
         height_ff <= HEIGHT_REG_W'(RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ----- rtl/core/cmb_line_stores.sv -----
// The two line stores: the row above the current one and the row two above it.
// Depends on cmb_pkg; read data is registered and appears in the cycle after the read enable.
module cmb_line_stores import cmb_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_col,
   input  logic [COL_W-1:0] right_col,
   input  logic [PIX_W-1:0] new_pixel,
   input  logic             older_wr_en,
   input  logic [COL_W-1:0] older_wr_col,
   input  logic [PIX_W-1:0] older_wr_pixel,
   output logic [PIX_W-1:0] above_px,
   output logic [PIX_W-1:0] right_px,
   output logic [PIX_W-1:0] up_px
);

   logic [PIX_W-1:0] prev_row_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] older_row_mem [MAX_WIDTH];
   logic [PIX_W-1:0] above_ff;
   logic [PIX_W-1:0] right_ff;
   logic [PIX_W-1:0] up_ff;

   // Previous row: read this column and the next, replace this column with the new pixel
   always_ff @(posedge clock) begin
      if (rd_en) begin
         above_ff             <= prev_row_mem[rd_col];
         right_ff             <= prev_row_mem[right_col];
         prev_row_mem[rd_col] <= new_pixel;
      end
   end

   // Older row: read at accept, written back when the item leaves the compute stage
   always_ff @(posedge clock) begin
      if (rd_en)
         up_ff <= older_row_mem[rd_col];
      if (older_wr_en)
         older_row_mem[older_wr_col] <= older_wr_pixel;
   end

   assign above_px = above_ff;
   assign right_px = right_ff;
   assign up_px    = up_ff;

endmodule

// ----- rtl/core/cmb_mean.sv -----
// Five-point truncated mean per colour channel, alpha forced opaque.
// Depends on cmb_pkg; divide by five is a constant reciprocal multiply.
module cmb_mean import cmb_pkg::*; (
   input  logic [PIX_W-1:0] up_px,
   input  logic [PIX_W-1:0] down_px,
   input  logic [PIX_W-1:0] left_px,
   input  logic [PIX_W-1:0] right_px,
   input  logic [PIX_W-1:0] self_px,
   output logic [PIX_W-1:0] mean_px
);

   logic [NUM_COLOUR-1:0][SUM_W-1:0]         chan_sum;
   logic [NUM_COLOUR-1:0][SUM_W+RECIP_W-1:0] chan_prod;

   // Sum each channel and scale by one fifth
   always_comb begin
      mean_px = '0;
      mean_px[ALPHA_SHIFT +: CHAN_W] = ALPHA_OPAQUE;
      for (int ch = 0; ch < NUM_COLOUR; ch++) begin
         chan_sum[ch] = SUM_W'(up_px[ch*CHAN_W +: CHAN_W])
                      + SUM_W'(down_px[ch*CHAN_W +: CHAN_W])
                      + SUM_W'(left_px[ch*CHAN_W +: CHAN_W])
                      + SUM_W'(right_px[ch*CHAN_W +: CHAN_W])
                      + SUM_W'(self_px[ch*CHAN_W +: CHAN_W]);
         chan_prod[ch] = (SUM_W+RECIP_W)'(chan_sum[ch])
                       * (SUM_W+RECIP_W)'(RECIP_FIVE);
         mean_px[ch*CHAN_W +: CHAN_W] = chan_prod[ch][RECIP_SHIFT +: CHAN_W];
      end
   end

endmodule

// ----- bench/tb_cross_mean_blur_argb_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the five-point cross mean filter: streams ARGB frames,
// predicts every filtered pixel with its own line-store model and checks each transfer.
// Depends on cmb_pkg and cross_mean_blur_argb_unit.
module tb_cross_mean_blur_argb_unit;
   import cmb_pkg::*;

   localparam int CROSS_TAPS    = 5;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PIXELS = 700;
   localparam int PRINT_LIMIT   = 100;
   // columns primed in both stores at the start; later widths stay within them
   localparam int FILL_WIDTH    = 40;
   localparam int SHORT_RUN     = 24;

   localparam logic [PIX_W-1:0] PIXEL_ALL_ONES  = {PIX_W{1'b1}};
   localparam logic [PIX_W-1:0] PIXEL_ALL_ZEROS = '0;

   // register indexes that decode to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             last_of_run;
   } filtered_pixel_type;

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic [PIX_W-1:0]       req_pixel_in    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic [COL_W-1:0]       rsp_column;
   logic [ROW_W-1:0]       rsp_row;
   logic                   rsp_last_of_run;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data        = '0;

   // handshake bookkeeping
   logic        req_xfer          = 1'b0;
   int unsigned cycle_count       = 0;
   int unsigned mismatch_count    = 0;
   int unsigned queued_count      = 0;
   int unsigned accepted_count    = 0;
   int unsigned sender_idle_pct   = 21;
   int unsigned receiver_idle_pct = 79;

   logic [PIX_W-1:0]   pixels_to_send[$];
   filtered_pixel_type expected_filtered[$];

   // shadow of the filter: geometry, position and both line stores
   logic [WIDTH_REG_W-1:0]  shadow_width  = WIDTH_REG_W'(RESET_WIDTH);
   logic [HEIGHT_REG_W-1:0] shadow_height = HEIGHT_REG_W'(RESET_HEIGHT);
   int unsigned             col_pos       = 0;
   int unsigned             row_pos       = 0;
   logic [PIX_W-1:0]        line_above     [MAX_WIDTH];
   logic [PIX_W-1:0]        line_two_above [MAX_WIDTH];

   cross_mean_blur_argb_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_column      (rsp_column),
      .rsp_row         (rsp_row),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // zero and oversize registers fall back to the legal range
   function automatic int unsigned active_width();
      int unsigned w;
      w = shadow_width;
      if (w == 0) w = 1;
      else if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = shadow_height;
      if (h == 0) h = 1;
      else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic int unsigned pixels_to_frame_end();
      int unsigned w, h, c, r;
      w = active_width();
      h = active_height();
      c = col_pos;
      r = row_pos;
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h) r = 0;
      return (h - r) * w - c;
   endfunction

   // truncated mean per colour channel, alpha forced opaque
   function automatic logic [PIX_W-1:0] five_point_mean(input logic [PIX_W-1:0] up, down,
                                                        left, right, centre);
      logic [PIX_W-1:0] mean;
      int unsigned      total;
      mean = {ALPHA_OPAQUE, {(PIX_W-CHAN_W){1'b0}}};
      for (int k = 0; k < NUM_COLOUR; k++) begin
         total = int'(up[k*CHAN_W +: CHAN_W]) + int'(down[k*CHAN_W +: CHAN_W])
               + int'(left[k*CHAN_W +: CHAN_W]) + int'(right[k*CHAN_W +: CHAN_W])
               + int'(centre[k*CHAN_W +: CHAN_W]);
         mean[k*CHAN_W +: CHAN_W] = CHAN_W'(total / CROSS_TAPS);
      end
      return mean;
   endfunction

   // advance the shadow by one accepted pixel and queue the results it causes
   task automatic filter_accepted_pixel(input logic [PIX_W-1:0] px);
      int unsigned        w, h, c, r;
      logic [PIX_W-1:0]   above;
      filtered_pixel_type res;
      w = active_width();
      h = active_height();
      c = col_pos;
      r = row_pos;
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h) r = 0;
      // emit the pixel one row up, filtered when it is interior
      if (r >= 1) begin
         above = line_above[c];
         res.pixel = above;
         if (r >= 2 && c >= 1 && c + 1 < w)
            res.pixel = five_point_mean(line_two_above[c], px, line_two_above[c-1],
                                        line_above[c+1], above);
         res.column      = COL_W'(c);
         res.row         = ROW_W'(r - 1);
         res.last_of_run = (r != h - 1);
         expected_filtered.push_back(res);
      end
      // shift the column down through both line stores
      line_two_above[c] = line_above[c];
      line_above[c]     = px;
      // the last row has nothing below it, so it emits itself at once
      if (r == h - 1) begin
         res.pixel       = px;
         res.column      = COL_W'(c);
         res.row         = ROW_W'(r);
         res.last_of_run = 1'b1;
         expected_filtered.push_back(res);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic report_mismatch(input string note);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, note);
      mismatch_count++;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [PIX_W-1:0] px;
      px = $urandom();
      case ($urandom_range(7))
         0: px = PIXEL_ALL_ZEROS;
         1: px = PIXEL_ALL_ONES;
         2: for (int k = 0; k < PIX_W / CHAN_W; k++)
               px[k*CHAN_W +: CHAN_W] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         default: ;
      endcase
      return px;
   endfunction

   // mostly tiny extents, now and then zero or a wider one
   function automatic logic [CSR_DATA_W-1:0] random_extent(input int unsigned widest);
      case ($urandom_range(9))
         0:       return '0;
         1, 2:    return CSR_DATA_W'($urandom_range(widest, 1));
         default: return CSR_DATA_W'($urandom_range(6, 1));
      endcase
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] px);
      pixels_to_send.push_back(px);
      queued_count++;
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // hold until every pixel is taken and every result is back, then let the pipe settle
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_filtered.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (index)
         CSR_IMAGE_WIDTH:  shadow_width  = value[WIDTH_REG_W-1:0];
         CSR_IMAGE_HEIGHT: shadow_height = value[HEIGHT_REG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drive the pixel channel and the result stall at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (pixels_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid    <= 1'b1;
            req_pixel_in <= pixels_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // sample both channels at the rising edge: predict on input, check on output
   always @(posedge clock) begin
      filtered_pixel_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         req_xfer = !reset && req_valid && (req_ready === 1'b1);
         if (req_xfer) begin
            filter_accepted_pixel(req_pixel_in);
            accepted_count++;
         end
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_filtered.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h at column %0d row %0d",
                                         rsp_pixel_out, rsp_column, rsp_row));
            end else begin
               want = expected_filtered.pop_front();
               if (rsp_pixel_out !== want.pixel)
                  report_mismatch($sformatf("pixel %h, want %h (column %0d row %0d)",
                                            rsp_pixel_out, want.pixel, want.column, want.row));
               if (rsp_column !== want.column)
                  report_mismatch($sformatf("column %0d, want %0d", rsp_column, want.column));
               if (rsp_row !== want.row)
                  report_mismatch($sformatf("row %0d, want %0d", rsp_row, want.row));
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, want %b (column %0d row %0d)",
                                            rsp_last_of_run, want.last_of_run,
                                            want.column, want.row));
            end
         end
      end
   end

   // stimulus: reset geometry, store priming, directed corners, then random frames
   initial begin
      int unsigned random_sent;
      int unsigned count;
      random_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry: one full row plus one, then cut the frame to two narrow rows
      // mid-way; this primes the first columns of both stores
      send_random(RESET_WIDTH + 1);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(FILL_WIDTH));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(2));
      send_random(pixels_to_frame_end());
      wait_idle();

      // 3 x 3 frames: all ones, then a checkerboard; the top data bit is ignored
      write_register(CSR_IMAGE_WIDTH, 13'h1003);
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3));
      for (int i = 0; i < 18; i++)
         send_pixel((i < 9 || i % 2 == 0) ? PIXEL_ALL_ONES : PIXEL_ALL_ZEROS);
      wait_idle();

      // zero extents act as one, writes to spare indexes change nothing
      write_register(CSR_IMAGE_WIDTH, '0);
      write_register(CSR_IMAGE_HEIGHT, '0);
      write_register(CSR_SPARE_A, CSR_DATA_W'($urandom()));
      write_register(CSR_SPARE_B, CSR_DATA_W'($urandom()));
      send_random(2);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(2));
      send_random(2);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(1));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(2));
      send_random(2);
      wait_idle();

      // shrink the width past the current column, then the height past the current row
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(8));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(4));
      send_random(6);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(4));
      send_random(5);
      wait_idle();
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(2));
      send_random(pixels_to_frame_end());
      wait_idle();

      // oversize width saturates; a one-row frame emits every pixel at once
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(12'hFFF));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(1));
      send_random(SHORT_RUN);
      wait_idle();

      // oversize height saturates on a one-column frame
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(1));
      write_register(CSR_IMAGE_HEIGHT, 13'h1FFF);
      send_random(SHORT_RUN);
      wait_idle();

      // back to a small frame before the random part
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(6));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(4));

      // random frames, mostly finished cleanly, some cut short by a geometry change
      while (random_sent < RANDOM_PIXELS) begin
         if (random_sent >= 2 * RANDOM_PIXELS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (random_sent >= RANDOM_PIXELS / 3) begin
            sender_idle_pct   = 79;
            receiver_idle_pct = 21;
         end
         if ($urandom_range(3) != 0)
            write_register(CSR_IMAGE_WIDTH, random_extent(FILL_WIDTH));
         if ($urandom_range(3) != 0)
            write_register(CSR_IMAGE_HEIGHT, random_extent(9));
         if ($urandom_range(15) == 0)
            write_register(($urandom_range(1) != 0) ? CSR_SPARE_A : CSR_SPARE_B,
                           CSR_DATA_W'($urandom()));
         if ($urandom_range(2) != 0)
            count = pixels_to_frame_end()
                  + $urandom_range(2) * active_width() * active_height();
         else
            count = $urandom_range(20, 1);
         send_random(count);
         random_sent += count;
         wait_idle();
      end

      repeat (16) @(negedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
